@@ src/assert_macros.svh @@
// Assertion macros for the RTL, used by uub_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define UUB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define UUB_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define UUB_ASSERT(lbl, prop, msg)
`define UUB_ASSERT_NXT(lbl, pre, post, msg)
`endif
`endif

@@ src/uub_pkg.sv @@
`timescale 1ns / 1ps
package uub_pkg;

  localparam int UUB_ITEM_SLOTS = 4096;
  localparam int UUB_BIN_WIDTH  = 48;
  localparam int ITEM_W         = 12;
  localparam int UTIL_W         = 32;
  localparam int OUT_BIN_W      = 48;
  localparam int IN_DATA_W      = 112;
  localparam int OUT_DATA_W     = 104;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_MARK  = 2'd1,
    OP_ELEM  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    VERDICT_DROP    = 2'd0,
    VERDICT_KEEP    = 2'd1,
    VERDICT_EXPLORE = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_E1,
    ST_E2,
    ST_E3,
    ST_RSLT
  } state_t;

  typedef struct packed {
    logic accept;
    logic clr_start;
    logic clr_step;
    logic e1;
    logic e2;
    logic e3;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic item_ok;
    logic kept;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

@@ src/uub_ctrl.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module uub_ctrl import uub_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          unique case (sts.op)
            OP_CLEAR: begin
              if (sts.item_ok) begin
                cmd.clr_start = 1'b1;
                state_nxt     = ST_CLR;
              end
            end
            OP_MARK: state_nxt = ST_IDLE;
            OP_ELEM: state_nxt = ST_E1;
            OP_READ: state_nxt = ST_RSLT;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_E1: begin
        cmd.e1    = 1'b1;
        state_nxt = sts.kept ? ST_E2 : ST_IDLE;
      end
      ST_E2: begin
        cmd.e2    = 1'b1;
        state_nxt = ST_E3;
      end
      ST_E3: begin
        cmd.e3    = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_RSLT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `UUB_ASSERT(a_one_cmd, $onehot0({cmd.accept, cmd.clr_step, cmd.e1, cmd.e2, cmd.e3, cmd.load_out}), "overlapping commands")
  `UUB_ASSERT_NXT(a_e1_e2, cmd.e1 && sts.kept, cmd.e2, "kept element skipped update")
  `UUB_ASSERT(a_load_free, !cmd.load_out || sts.out_free, "result overwrote pending output")

endmodule

@@ src/uub_dp.sv @@
`timescale 1ns / 1ps
module uub_dp import uub_pkg::*; #(
  parameter int ITEM_SLOTS = UUB_ITEM_SLOTS,
  parameter int BIN_WIDTH  = UUB_BIN_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  cfg_wr_en,
  input  logic [OUT_BIN_W-1:0]  cfg_wr_data,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int AW = $clog2(ITEM_SLOTS);
  localparam int SW = ((BIN_WIDTH > UTIL_W) ? BIN_WIDTH : UTIL_W) + 1;
  localparam int CW = (BIN_WIDTH > OUT_BIN_W) ? BIN_WIDTH : OUT_BIN_W;
  localparam logic [SW-1:0] BIN_MAX = (SW'(1) << BIN_WIDTH) - SW'(1);

  function automatic logic [SW-1:0] sat(input logic [SW-1:0] a, input logic [SW-1:0] b);
    logic [SW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, BIN_MAX}) ? BIN_MAX : s[SW-1:0];
  endfunction

  op_t               in_op;
  logic [ITEM_W-1:0] in_item;
  logic              in_ok;
  logic [AW-1:0]     in_addr;

  assign in_op   = op_t'(in_tdata[1:0]);
  assign in_item = in_tdata[13:2];
  assign in_ok   = 32'(in_item) < 32'(ITEM_SLOTS);
  assign in_addr = AW'(in_item);

  logic                 flag_mem [ITEM_SLOTS];
  logic [2*BIN_WIDTH-1:0] bin_mem [ITEM_SLOTS];

  logic                 item_ok_r, start_r, flag_q;
  logic [AW-1:0]        addr_r, ptr_r;
  logic [UTIL_W-1:0]    util_r, pre_r, tu_r;
  logic [BIN_WIDTH-1:0] sub_q, loc_q, sum_r, tmp_a_r, tmp_b_r, loc_new_r;
  logic [OUT_BIN_W-1:0] minu_r;
  logic                 out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [BIN_WIDTH-1:0] base, sub_new, su, lu;
  verdict_t             verdict;

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      flag_mem[ptr_r] <= 1'b0;
    end else if (cmd.accept && in_op == OP_MARK && in_ok) begin
      flag_mem[in_addr] <= 1'b1;
    end
    if (cmd.accept) begin
      flag_q <= flag_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      bin_mem[ptr_r] <= '0;
    end else if (cmd.e3) begin
      bin_mem[addr_r] <= {sub_new, loc_new_r};
    end
    if (cmd.accept) begin
      {sub_q, loc_q} <= bin_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_ok_r <= in_ok;
      addr_r    <= in_addr;
      util_r    <= in_tdata[45:14];
      pre_r     <= in_tdata[77:46];
      tu_r      <= in_tdata[109:78];
      start_r   <= in_tuser;
    end
    if (cmd.e1) begin
      tmp_a_r <= BIN_WIDTH'(sat(SW'(tu_r), SW'(pre_r)));
    end
    if (cmd.e2) begin
      tmp_b_r   <= BIN_WIDTH'(sat(SW'(sum_r), SW'(pre_r)));
      loc_new_r <= BIN_WIDTH'(sat(SW'(loc_q), SW'(tmp_a_r)));
    end
    if (cmd.load_out) begin
      out_tdata_r <= {6'd0, verdict, 48'(lu), 48'(su)};
    end
  end

  assign base    = start_r ? '0 : sum_r;
  assign sub_new = BIN_WIDTH'(sat(SW'(sub_q), SW'(tmp_b_r)));
  assign su      = item_ok_r ? sub_q : '0;
  assign lu      = item_ok_r ? loc_q : '0;

  always_comb begin
    if (CW'(su) >= CW'(minu_r)) begin
      verdict = VERDICT_EXPLORE;
    end else if (CW'(lu) >= CW'(minu_r)) begin
      verdict = VERDICT_KEEP;
    end else begin
      verdict = VERDICT_DROP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r        <= '0;
      ptr_r        <= '0;
      minu_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cmd.e1) begin
        sum_r <= sts.kept ? BIN_WIDTH'(sat(SW'(base), SW'(util_r))) : base;
      end
      if (cmd.clr_start) begin
        ptr_r <= in_addr;
      end else if (cmd.clr_step) begin
        ptr_r <= ptr_r + AW'(1);
      end
      if (cfg_wr_en) begin
        minu_r <= cfg_wr_data;
      end
      if (cmd.load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign sts.op       = in_op;
  assign sts.item_ok  = in_ok;
  assign sts.kept     = item_ok_r && flag_q;
  assign sts.clr_last = ptr_r == AW'(ITEM_SLOTS - 1);
  assign sts.out_free = !out_tvalid_r || out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

@@ src/utility_upper_bound_bins_top.sv @@
`timescale 1ns / 1ps
// channel | dir | tdata (low bit up)                            | tuser
// in      | in  | op, item_id, utility, prefix util,            | start_of_transaction
//         |     | trans util, zero pad to 112                   |
// out     | out | subtree_bound, local_bound, verdict, pad->104 | -
// cfg     | in  | cfg_wr_data = min_utility, written on cfg_wr_en
// Mark: done on acceptance. Read: then the result state, held there while the output register is held.
// Element: accept, then E1; a kept item goes on through E2 and E3 (three dependent saturating adds).
// Clear from item k: entries k up to ITEM_SLOTS - 1 are cleared, one entry per cycle.
// After reset a clearing pass over all ITEM_SLOTS entries runs before in_tready rises.
// A waiting result stalls the input only once a following read reaches its result cycle.
module utility_upper_bound_bins_top import uub_pkg::*; #(
  parameter int ITEM_SLOTS = UUB_ITEM_SLOTS,
  parameter int BIN_WIDTH  = UUB_BIN_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // op, item_id, utility, prefix, trans utility
  input  logic                  in_tuser,   // start_of_transaction
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // subtree_bound, local_bound, verdict
  input  logic                  cfg_wr_en,
  input  logic [OUT_BIN_W-1:0]  cfg_wr_data
);

  cmd_t cmd;
  sts_t sts;

  uub_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  uub_dp #(
    .ITEM_SLOTS (ITEM_SLOTS),
    .BIN_WIDTH  (BIN_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule
